@@ hw/rtl/ffdx_pkg.sv @@
`default_nettype none
package ffdx_pkg;

   localparam logic [7:0] FLAG_BYTE     = 8'h7e;
   localparam logic [7:0] ESC_BYTE      = 8'h7d;
   localparam logic [7:0] ESC_FLAG_CODE = 8'h02;
   localparam logic [7:0] ESC_ESC_CODE  = 8'h01;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SHORT    = 2'd1;
   localparam logic [1:0] STATUS_MISMATCH = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

   // Minimum kept byte counts, header plus check byte.
   localparam int unsigned MIN_PLAIN  = 13;
   localparam int unsigned MIN_PACKET = 17;
   localparam int unsigned HEADER_BYTES = 16;
   localparam int unsigned PACKET_BIT = 13;

   localparam int unsigned OFFSET_W = 11;

   typedef struct packed {
      logic                kind;
      logic [7:0]          data_byte;
      logic [OFFSET_W-1:0] byte_offset;
      logic [15:0]         msg_id;
      logic [15:0]         body_attribute;
      logic [47:0]         terminal_number;
      logic [15:0]         serial_number;
      logic [15:0]         total_packets;
      logic [15:0]         packet_index;
      logic [1:0]          status;
   } rsp_payload_type;

endpackage
`default_nettype wire

@@ hw/rtl/ffdx_req_if.sv @@
`default_nettype none
interface ffdx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ffdx_rsp_if.sv @@
`default_nettype none
interface ffdx_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             kind;
   logic [7:0]                       data_byte;
   logic [ffdx_pkg::OFFSET_W-1:0]    byte_offset;
   logic [15:0]                      msg_id;
   logic [15:0]                      body_attribute;
   logic [47:0]                      terminal_number;
   logic [15:0]                      serial_number;
   logic [15:0]                      total_packets;
   logic [15:0]                      packet_index;
   logic [1:0]                       status;

   modport source (output valid, output kind, output data_byte, output byte_offset,
                   output msg_id, output body_attribute, output terminal_number,
                   output serial_number, output total_packets, output packet_index,
                   output status, input ready);
   modport sink   (input valid, input kind, input data_byte, input byte_offset,
                   input msg_id, input body_attribute, input terminal_number,
                   input serial_number, input total_packets, input packet_index,
                   input status, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/flag_framed_deframer_xor_check.sv @@
`default_nettype none
// Channel   Direction  Contents
// req_ch    in         one raw line byte per request (rx_byte)
// rsp_ch    out        payload byte or end-of-frame record with header and status
//
// One raw byte is taken per cycle while the result side does not stall. Its result, if
// any, is registered in the result register from a single pass of escape, XOR and
// header logic; a payload byte is only released when the next kept byte arrives. An
// input register and a result register decouple the two sides, so one further request
// is taken while a result waits. Synchronous reset returns the deframer to flag hunting
// with no request or result held.
module flag_framed_deframer_xor_check #(
   parameter int unsigned MAX_FRAME_BYTES = 2048
) (
   input  wire         clock,
   input  wire         reset,
   ffdx_req_if.sink    req_ch,
   ffdx_rsp_if.source  rsp_ch
);

   localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_FRAME_BYTES - 1);

   // Input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // Frame state
   logic             in_frame_ff, in_frame_in;
   logic             esc_ff, esc_in;
   logic             raw_seen_ff, raw_seen_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       held_ff, held_in;
   logic             held_valid_ff, held_valid_in;
   logic             overflow_ff, overflow_in;
   logic [15:0]      hdr_id_ff, hdr_id_in;
   logic [15:0]      hdr_attr_ff, hdr_attr_in;
   logic [47:0]      hdr_term_ff, hdr_term_in;
   logic [15:0]      hdr_serial_ff, hdr_serial_in;
   logic [15:0]      hdr_total_ff, hdr_total_in;
   logic [15:0]      hdr_index_ff, hdr_index_in;

   // Result register
   logic                      rsp_valid_ff;
   ffdx_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic             advance;
   logic             emit;
   logic             accept_ub;
   logic [7:0]       ub;
   logic [CNT_W-1:0] off;
   logic [CNT_W-1:0] len;
   logic [CNT_W-1:0] need;
   logic             pk;
   logic [1:0]       status;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_frame_in   = in_frame_ff;
      esc_in        = esc_ff;
      raw_seen_in   = raw_seen_ff;
      count_in      = count_ff;
      xor_in        = xor_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      overflow_in   = overflow_ff;
      hdr_id_in     = hdr_id_ff;
      hdr_attr_in   = hdr_attr_ff;
      hdr_term_in   = hdr_term_ff;
      hdr_serial_in = hdr_serial_ff;
      hdr_total_in  = hdr_total_ff;
      hdr_index_in  = hdr_index_ff;
      emit          = 1'b0;
      accept_ub     = 1'b0;
      ub            = in_byte_ff;
      off           = count_ff - CNT_W'(1);
      len           = (count_ff != '0) ? count_ff - CNT_W'(1) : '0;
      pk            = hdr_attr_ff[ffdx_pkg::PACKET_BIT];
      need          = pk ? CNT_W'(ffdx_pkg::MIN_PACKET) : CNT_W'(ffdx_pkg::MIN_PLAIN);
      rsp_in        = rsp_ff;

      if (overflow_ff) begin
         status = ffdx_pkg::STATUS_OVERFLOW;
      end else if (count_ff < need) begin
         status = ffdx_pkg::STATUS_SHORT;
      end else if (xor_ff != 8'h00) begin
         status = ffdx_pkg::STATUS_MISMATCH;
      end else begin
         status = ffdx_pkg::STATUS_OK;
      end

      if (in_valid_ff && advance) begin
         if (!in_frame_ff || (in_byte_ff == ffdx_pkg::FLAG_BYTE && !raw_seen_ff)) begin
            // Hunting, or an empty frame: a flag (re)opens a clean frame.
            if (in_byte_ff == ffdx_pkg::FLAG_BYTE) begin
               in_frame_in   = 1'b1;
               esc_in        = 1'b0;
               raw_seen_in   = 1'b0;
               count_in      = '0;
               xor_in        = '0;
               held_in       = '0;
               held_valid_in = 1'b0;
               overflow_in   = 1'b0;
               hdr_id_in     = '0;
               hdr_attr_in   = '0;
               hdr_term_in   = '0;
               hdr_serial_in = '0;
               hdr_total_in  = '0;
               hdr_index_in  = '0;
            end
         end else if (in_byte_ff == ffdx_pkg::FLAG_BYTE) begin
            emit          = 1'b1;
            in_frame_in   = 1'b0;
            esc_in        = 1'b0;
            held_valid_in = 1'b0;
            rsp_in.kind        = ffdx_pkg::KIND_END;
            rsp_in.data_byte   = '0;
            rsp_in.byte_offset = ffdx_pkg::OFFSET_W'(len);
            rsp_in.status      = status;
         end else begin
            raw_seen_in = 1'b1;
            if (esc_ff) begin
               esc_in = 1'b0;
               if (in_byte_ff == ffdx_pkg::ESC_FLAG_CODE) begin
                  accept_ub = 1'b1;
                  ub        = ffdx_pkg::FLAG_BYTE;
               end else if (in_byte_ff == ffdx_pkg::ESC_ESC_CODE) begin
                  accept_ub = 1'b1;
                  ub        = ffdx_pkg::ESC_BYTE;
               end
            end else if (in_byte_ff == ffdx_pkg::ESC_BYTE) begin
               esc_in = 1'b1;
            end else begin
               accept_ub = 1'b1;
            end
         end

         if (accept_ub) begin
            if (count_ff >= CNT_LIMIT) begin
               overflow_in = 1'b1;
            end else begin
               if (held_valid_ff) begin
                  // The byte leaving the hold stage fills the header first.
                  if (off < CNT_W'(2)) begin
                     hdr_id_in = {hdr_id_ff[7:0], held_ff};
                  end else if (off < CNT_W'(4)) begin
                     hdr_attr_in = {hdr_attr_ff[7:0], held_ff};
                  end else if (off < CNT_W'(10)) begin
                     hdr_term_in = {hdr_term_ff[39:0], held_ff};
                  end else if (off < CNT_W'(12)) begin
                     hdr_serial_in = {hdr_serial_ff[7:0], held_ff};
                  end else if (off < CNT_W'(14)) begin
                     hdr_total_in = {hdr_total_ff[7:0], held_ff};
                  end else if (off < CNT_W'(ffdx_pkg::HEADER_BYTES)) begin
                     hdr_index_in = {hdr_index_ff[7:0], held_ff};
                  end
                  emit               = 1'b1;
                  rsp_in.kind        = ffdx_pkg::KIND_PAYLOAD;
                  rsp_in.data_byte   = held_ff;
                  rsp_in.byte_offset = ffdx_pkg::OFFSET_W'(off);
                  rsp_in.status      = ffdx_pkg::STATUS_OK;
               end
               xor_in        = xor_ff ^ ub;
               held_in       = ub;
               held_valid_in = 1'b1;
               count_in      = count_ff + CNT_W'(1);
            end
         end

         if (emit) begin
            rsp_in.msg_id          = hdr_id_in;
            rsp_in.body_attribute  = hdr_attr_in;
            rsp_in.terminal_number = hdr_term_in;
            rsp_in.serial_number   = hdr_serial_in;
            if (hdr_attr_in[ffdx_pkg::PACKET_BIT]) begin
               rsp_in.total_packets = hdr_total_in;
               rsp_in.packet_index  = hdr_index_in;
            end else begin
               rsp_in.total_packets = '0;
               rsp_in.packet_index  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         in_frame_ff   <= 1'b0;
         esc_ff        <= 1'b0;
         raw_seen_ff   <= 1'b0;
         count_ff      <= '0;
         xor_ff        <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         overflow_ff   <= 1'b0;
         hdr_id_ff     <= '0;
         hdr_attr_ff   <= '0;
         hdr_term_ff   <= '0;
         hdr_serial_ff <= '0;
         hdr_total_ff  <= '0;
         hdr_index_ff  <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            rsp_valid_ff <= emit;
         end
         in_frame_ff   <= in_frame_in;
         esc_ff        <= esc_in;
         raw_seen_ff   <= raw_seen_in;
         count_ff      <= count_in;
         xor_ff        <= xor_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         overflow_ff   <= overflow_in;
         hdr_id_ff     <= hdr_id_in;
         hdr_attr_ff   <= hdr_attr_in;
         hdr_term_ff   <= hdr_term_in;
         hdr_serial_ff <= hdr_serial_in;
         hdr_total_ff  <= hdr_total_in;
         hdr_index_ff  <= hdr_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff <= req_ch.rx_byte;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.kind            = rsp_ff.kind;
   assign rsp_ch.data_byte       = rsp_ff.data_byte;
   assign rsp_ch.byte_offset     = rsp_ff.byte_offset;
   assign rsp_ch.msg_id          = rsp_ff.msg_id;
   assign rsp_ch.body_attribute  = rsp_ff.body_attribute;
   assign rsp_ch.terminal_number = rsp_ff.terminal_number;
   assign rsp_ch.serial_number   = rsp_ff.serial_number;
   assign rsp_ch.total_packets   = rsp_ff.total_packets;
   assign rsp_ch.packet_index    = rsp_ff.packet_index;
   assign rsp_ch.status          = rsp_ff.status;

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

   localparam int FRAME_LIMIT  = 2048;
   localparam int RANDOM_BYTES = 200;
   localparam int STALL_LIMIT  = 2000;

   typedef logic [7:0] octet_q_type[$];

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       line_valid = 1'b0;
   logic [7:0] line_byte = 8'h00;
   logic       sink_ready = 1'b0;
   bit         steady_flow = 1'b0;
   int         sink_hold = 0;
   int         quiet_cycles = 0;

   int line_bytes_sent = 0;
   int payload_seen = 0;
   int end_status_seen [4];
   int mismatch_count = 0;

   ffdx_req_if req_ch ();
   ffdx_rsp_if rsp_ch ();

   assign req_ch.valid   = line_valid;
   assign req_ch.rx_byte = line_byte;
   assign rsp_ch.ready   = sink_ready;

   flag_framed_deframer_xor_check #(.MAX_FRAME_BYTES(FRAME_LIMIT)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #6 clock = ~clock;

   // Deframer state as predicted from the accepted line bytes.
   bit          framing;
   bit          escape_armed;
   int          raw_bytes;
   int          kept_bytes;
   logic [7:0]  frame_xor;
   logic [7:0]  held_octet;
   bit          held_live;
   bit          overrun;
   logic [15:0] hdr_id;
   logic [15:0] hdr_attr;
   logic [47:0] hdr_term;
   logic [15:0] hdr_serial;
   logic [15:0] hdr_total;
   logic [15:0] hdr_index;

   ffdx_pkg::rsp_payload_type expected_records[$];

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // Biased towards flag and escape values so that escaping is exercised often.
   function automatic logic [7:0] pick_octet();
      int roll;
      logic [7:0] value;
      roll = $urandom_range(0, 99);
      value = 8'($urandom_range(0, 255));
      if (roll < 12) value = ffdx_pkg::FLAG_BYTE;
      else if (roll < 24) value = ffdx_pkg::ESC_BYTE;
      else if (roll < 28) value = ffdx_pkg::ESC_FLAG_CODE;
      else if (roll < 32) value = ffdx_pkg::ESC_ESC_CODE;
      return value;
   endfunction

   task automatic clear_frame_state();
      escape_armed = 1'b0;
      raw_bytes = 0;
      kept_bytes = 0;
      frame_xor = 8'h00;
      held_octet = 8'h00;
      held_live = 1'b0;
      overrun = 1'b0;
      hdr_id = '0;
      hdr_attr = '0;
      hdr_term = '0;
      hdr_serial = '0;
      hdr_total = '0;
      hdr_index = '0;
   endtask

   function automatic ffdx_pkg::rsp_payload_type make_record(logic kind, logic [7:0] data,
                                                             int offset, logic [1:0] status);
      ffdx_pkg::rsp_payload_type rec;
      bit packet;
      packet = hdr_attr[ffdx_pkg::PACKET_BIT];
      rec.kind = kind;
      rec.data_byte = data;
      rec.byte_offset = offset[ffdx_pkg::OFFSET_W-1:0];
      rec.msg_id = hdr_id;
      rec.body_attribute = hdr_attr;
      rec.terminal_number = hdr_term;
      rec.serial_number = hdr_serial;
      rec.total_packets = packet ? hdr_total : 16'h0000;
      rec.packet_index = packet ? hdr_index : 16'h0000;
      rec.status = status;
      return rec;
   endfunction

   task automatic capture_header(input int off, input logic [7:0] value);
      if (off < 2) hdr_id = {hdr_id[7:0], value};
      else if (off < 4) hdr_attr = {hdr_attr[7:0], value};
      else if (off < 10) hdr_term = {hdr_term[39:0], value};
      else if (off < 12) hdr_serial = {hdr_serial[7:0], value};
      else if (off < 14) hdr_total = {hdr_total[7:0], value};
      else if (off < int'(ffdx_pkg::HEADER_BYTES)) hdr_index = {hdr_index[7:0], value};
   endtask

   // The byte before is released only when a new one is kept, so the check
   // byte never leaves as payload.
   task automatic keep_octet(input logic [7:0] value);
      if (kept_bytes >= FRAME_LIMIT - 1) begin
         overrun = 1'b1;
         return;
      end
      if (held_live) begin
         capture_header(kept_bytes - 1, held_octet);
         expected_records.push_back(make_record(ffdx_pkg::KIND_PAYLOAD, held_octet,
                                                kept_bytes - 1, ffdx_pkg::STATUS_OK));
      end
      frame_xor ^= value;
      held_octet = value;
      held_live = 1'b1;
      kept_bytes++;
   endtask

   task automatic predict_line_byte(input logic [7:0] value);
      logic [1:0] status;
      int need;
      if (!framing) begin
         if (value == ffdx_pkg::FLAG_BYTE) begin
            clear_frame_state();
            framing = 1'b1;
         end
         return;
      end
      if (value == ffdx_pkg::FLAG_BYTE) begin
         // A flag straight after the opening one simply reopens the frame.
         if (raw_bytes == 0) begin
            clear_frame_state();
            return;
         end
         need = hdr_attr[ffdx_pkg::PACKET_BIT] ? int'(ffdx_pkg::MIN_PACKET)
                                               : int'(ffdx_pkg::MIN_PLAIN);
         if (overrun) status = ffdx_pkg::STATUS_OVERFLOW;
         else if (kept_bytes < need) status = ffdx_pkg::STATUS_SHORT;
         else if (frame_xor != 8'h00) status = ffdx_pkg::STATUS_MISMATCH;
         else status = ffdx_pkg::STATUS_OK;
         expected_records.push_back(make_record(ffdx_pkg::KIND_END, 8'h00,
                                                kept_bytes > 0 ? kept_bytes - 1 : 0, status));
         framing = 1'b0;
         escape_armed = 1'b0;
         held_live = 1'b0;
         return;
      end
      if (raw_bytes < 4095) raw_bytes++;
      if (escape_armed) begin
         escape_armed = 1'b0;
         if (value == ffdx_pkg::ESC_FLAG_CODE) keep_octet(ffdx_pkg::FLAG_BYTE);
         else if (value == ffdx_pkg::ESC_ESC_CODE) keep_octet(ffdx_pkg::ESC_BYTE);
         return;
      end
      if (value == ffdx_pkg::ESC_BYTE) begin
         escape_armed = 1'b1;
         return;
      end
      keep_octet(value);
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   task automatic check_record(input ffdx_pkg::rsp_payload_type got,
                               input ffdx_pkg::rsp_payload_type want);
      compare_field("kind", 64'(got.kind), 64'(want.kind));
      compare_field("data_byte", 64'(got.data_byte), 64'(want.data_byte));
      compare_field("byte_offset", 64'(got.byte_offset), 64'(want.byte_offset));
      compare_field("msg_id", 64'(got.msg_id), 64'(want.msg_id));
      compare_field("body_attribute", 64'(got.body_attribute), 64'(want.body_attribute));
      compare_field("terminal_number", 64'(got.terminal_number),
                    64'(want.terminal_number));
      compare_field("serial_number", 64'(got.serial_number), 64'(want.serial_number));
      compare_field("total_packets", 64'(got.total_packets), 64'(want.total_packets));
      compare_field("packet_index", 64'(got.packet_index), 64'(want.packet_index));
      compare_field("status", 64'(got.status), 64'(want.status));
   endtask

   // Result side: random stalls unless steady flow is asked for.
   always @(posedge clock) begin
      if (sink_hold > 0) begin
         sink_ready <= 1'b0;
         sink_hold <= sink_hold - 1;
      end else begin
         sink_ready <= 1'b1;
         sink_hold <= steady_flow ? 0 : pick_gap();
      end
   end

   always @(posedge clock) begin : result_check
      ffdx_pkg::rsp_payload_type got;
      ffdx_pkg::rsp_payload_type want;
      if (!reset && rsp_ch.valid && sink_ready) begin
         got.kind = rsp_ch.kind;
         got.data_byte = rsp_ch.data_byte;
         got.byte_offset = rsp_ch.byte_offset;
         got.msg_id = rsp_ch.msg_id;
         got.body_attribute = rsp_ch.body_attribute;
         got.terminal_number = rsp_ch.terminal_number;
         got.serial_number = rsp_ch.serial_number;
         got.total_packets = rsp_ch.total_packets;
         got.packet_index = rsp_ch.packet_index;
         got.status = rsp_ch.status;
         if (expected_records.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, kind %0d offset %0d",
                                      got.kind, got.byte_offset));
         end else begin
            want = expected_records.pop_front();
            check_record(got, want);
            if (want.kind == ffdx_pkg::KIND_END) end_status_seen[want.status]++;
            else payload_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (line_valid && req_ch.ready) || (rsp_ch.valid && sink_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no request or result moved for %0d cycles.", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic send_line_byte(input logic [7:0] value);
      int gap;
      gap = steady_flow ? 0 : pick_gap();
      if (gap > 0) begin
         line_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      line_valid <= 1'b1;
      line_byte <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_line_byte(value);
      line_bytes_sent++;
   endtask

   task automatic send_escaped(input logic [7:0] value);
      if (value == ffdx_pkg::FLAG_BYTE) begin
         send_line_byte(ffdx_pkg::ESC_BYTE);
         send_line_byte(ffdx_pkg::ESC_FLAG_CODE);
      end else if (value == ffdx_pkg::ESC_BYTE) begin
         send_line_byte(ffdx_pkg::ESC_BYTE);
         send_line_byte(ffdx_pkg::ESC_ESC_CODE);
      end else begin
         send_line_byte(value);
      end
   endtask

   task automatic send_frame(input octet_q_type content, input bit spoil_check);
      logic [7:0] check;
      logic [7:0] spoil;
      check = 8'h00;
      send_line_byte(ffdx_pkg::FLAG_BYTE);
      foreach (content[i]) begin
         check ^= content[i];
         send_escaped(content[i]);
      end
      if (spoil_check) begin
         spoil = 8'($urandom_range(1, 255));
         check ^= spoil;
      end
      send_escaped(check);
      send_line_byte(ffdx_pkg::FLAG_BYTE);
   endtask

   task automatic make_frame(input bit packet, input int body_len,
                             output octet_q_type content);
      logic [15:0] attr;
      content = {};
      attr = 16'($urandom_range(0, 65535));
      attr[ffdx_pkg::PACKET_BIT] = packet;
      repeat (2) content.push_back(pick_octet());
      content.push_back(attr[15:8]);
      content.push_back(attr[7:0]);
      repeat (8) content.push_back(pick_octet());
      if (packet) repeat (4) content.push_back(pick_octet());
      repeat (body_len) content.push_back(pick_octet());
   endtask

   // Hunting noise, an empty frame, escape at close, one-byte frame, and good,
   // bad and doubled escapes.
   task automatic test_special_cases();
      octet_q_type seq;
      seq = {8'h00, 8'hff, ffdx_pkg::ESC_BYTE, 8'h55,
             ffdx_pkg::FLAG_BYTE, ffdx_pkg::FLAG_BYTE, ffdx_pkg::ESC_BYTE,
             ffdx_pkg::FLAG_BYTE,
             ffdx_pkg::FLAG_BYTE, 8'h01, ffdx_pkg::FLAG_BYTE,
             ffdx_pkg::FLAG_BYTE, ffdx_pkg::ESC_BYTE, ffdx_pkg::ESC_FLAG_CODE,
             ffdx_pkg::ESC_BYTE, ffdx_pkg::ESC_ESC_CODE,
             ffdx_pkg::ESC_BYTE, 8'h55, ffdx_pkg::ESC_BYTE, ffdx_pkg::ESC_BYTE, 8'h33,
             ffdx_pkg::FLAG_BYTE};
      foreach (seq[i]) send_line_byte(seq[i]);
   endtask

   task automatic test_header_frames();
      octet_q_type content;
      content = {};
      repeat (12) content.push_back(8'hff);
      send_frame(content, 1'b0);
      repeat (4) content.push_back(8'hff);
      send_frame(content, 1'b0);
      content = {};
      repeat (12) content.push_back(8'h00);
      send_frame(content, 1'b0);
      make_frame(1'b1, 0, content);
      send_frame(content, 1'b0);
      make_frame(1'b0, 3, content);
      send_frame(content, 1'b0);
      make_frame(1'b0, 2, content);
      send_frame(content, 1'b1);
      make_frame(1'b1, 0, content);
      repeat (3) void'(content.pop_back());
      send_frame(content, 1'b0);
   endtask

   // The body fills the kept-byte limit exactly, so the check byte is the first
   // one past it. Plain body bytes keep the line length close to the limit.
   task automatic test_overflow();
      octet_q_type content;
      make_frame(1'b0, 0, content);
      while (content.size() < FRAME_LIMIT - 1)
         content.push_back(8'($urandom_range(0, 8'h7c)));
      send_frame(content, 1'b0);
   endtask

   task automatic test_back_to_back();
      octet_q_type content;
      steady_flow = 1'b1;
      repeat (6) begin
         make_frame(1'($urandom_range(0, 1)), $urandom_range(0, 10), content);
         send_frame(content, $urandom_range(0, 3) == 0);
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_random_traffic();
      octet_q_type content;
      int target;
      int roll;
      int body;
      int cut;
      logic [7:0] check;
      logic [7:0] junk;
      target = line_bytes_sent + RANDOM_BYTES;
      while (line_bytes_sent < target) begin
         roll = $urandom_range(0, 99);
         body = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
         make_frame(1'($urandom_range(0, 1)), body, content);
         if (roll < 78) begin
            send_frame(content, $urandom_range(0, 6) == 0);
         end else if (roll < 88) begin
            // Frame cut short, sometimes ending on a dangling escape.
            cut = $urandom_range(0, content.size());
            send_line_byte(ffdx_pkg::FLAG_BYTE);
            for (int i = 0; i < cut; i++) send_escaped(content[i]);
            if ($urandom_range(0, 1) == 1) send_line_byte(ffdx_pkg::ESC_BYTE);
            send_line_byte(ffdx_pkg::FLAG_BYTE);
         end else if (roll < 94) begin
            // Stray escapes with arbitrary followers scattered through the frame.
            check = 8'h00;
            send_line_byte(ffdx_pkg::FLAG_BYTE);
            foreach (content[i]) begin
               if ($urandom_range(0, 7) == 0) begin
                  junk = 8'($urandom_range(0, 255));
                  send_line_byte(ffdx_pkg::ESC_BYTE);
                  send_line_byte(junk);
               end
               check ^= content[i];
               send_escaped(content[i]);
            end
            send_escaped(check);
            send_line_byte(ffdx_pkg::FLAG_BYTE);
         end else begin
            repeat ($urandom_range(1, 30)) begin
               junk = ($urandom_range(0, 3) == 0) ? pick_octet()
                                                  : 8'($urandom_range(0, 255));
               send_line_byte(junk);
            end
            // A trailing flag brings the deframer back to a frame boundary.
            send_line_byte(ffdx_pkg::FLAG_BYTE);
         end
      end
   endtask

   initial begin
      framing = 1'b0;
      clear_frame_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_cases();
      test_header_frames();
      test_overflow();
      test_back_to_back();
      test_random_traffic();

      line_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d line bytes; checked %0d payload bytes and %0d frame ends.",
               line_bytes_sent, payload_seen,
               end_status_seen[0] + end_status_seen[1] + end_status_seen[2]
               + end_status_seen[3]);
      $display("Frame ends by status: ok %0d, short %0d, check mismatch %0d, overflow %0d.",
               end_status_seen[ffdx_pkg::STATUS_OK], end_status_seen[ffdx_pkg::STATUS_SHORT],
               end_status_seen[ffdx_pkg::STATUS_MISMATCH],
               end_status_seen[ffdx_pkg::STATUS_OVERFLOW]);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ flag_framed_deframer_xor_check.f @@
hw/rtl/ffdx_pkg.sv
hw/rtl/ffdx_req_if.sv
hw/rtl/ffdx_rsp_if.sv
hw/rtl/flag_framed_deframer_xor_check.sv
dv/testbench.sv
